// ===== src/genotype_phenotype_count_table_defines.svh =====
// ----------------------------------------------------------------------------
// genotype_phenotype_count_table_defines
// assertion macros shared by the count table rtl
// ----------------------------------------------------------------------------
`ifndef GENOTYPE_PHENOTYPE_COUNT_TABLE_DEFINES_SVH
`define GENOTYPE_PHENOTYPE_COUNT_TABLE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GPCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GPCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/gpct_pkg.sv =====
// ----------------------------------------------------------------------------
// gpct_pkg
// constants, types and helper functions of the genotype/phenotype count table
// ----------------------------------------------------------------------------
package gpct_pkg;

    localparam int MAX_CLASSES      = 15;
    localparam int GENOTYPE_COLUMNS = 4;
    localparam int COUNT_BITS       = 20;

    localparam int ROW_BITS   = 4;
    localparam int COL_BITS   = 2;
    localparam int ADDR_BITS  = ROW_BITS + COL_BITS;
    localparam int CELL_DEPTH = 1 << ADDR_BITS;
    localparam int OUT_BITS   = 20;
    localparam int WIDE_BITS  = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;

    typedef logic [ROW_BITS-1:0]   row_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [ADDR_BITS-1:0]  addr_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [OUT_BITS-1:0]   out_count_t;

    localparam count_t     CELL_FULL = '1;
    localparam out_count_t OUT_FULL  = '1;
    localparam col_t       LAST_COL  = COL_BITS'(GENOTYPE_COLUMNS - 1);

    // readout sequencer states
    typedef enum logic [1:0] {
        RD_IDLE,
        RD_ISSUE,
        RD_WAIT,
        RD_SUM
    } rd_state_t;

    // readout to sample path and memory port
    typedef struct packed {
        logic  busy;
        logic  clear;
        logic  rd_en;
        addr_t rd_addr;
    } rdo_ctl_t;

    // sample path to readout
    typedef struct packed {
        logic final_done;
        logic cell_valid;
    } smp_stat_t;

    // cell address from row and column
    function automatic addr_t cell_addr(row_t row, col_t col);
        return {row, col};
    endfunction

    // saturating sum of two counts
    function automatic count_t sat_add(count_t a, count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > {1'b0, CELL_FULL})
            return CELL_FULL;
        return s[COUNT_BITS-1:0];
    endfunction

    // clamp a count to the output field width
    function automatic out_count_t fit_out(count_t c);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(c);
        if (w > WIDE_BITS'(OUT_FULL))
            return OUT_FULL;
        return OUT_BITS'(w);
    endfunction

endpackage

// ===== src/genotype_phenotype_count_table.sv =====
// Samples: one accepted per cycle while intake is open; a counter update is written
// from the sample stage in the cycle after its beat. Readout of (classes+1)*4 beats
// after the final sample: memory read then output load per true-row cell, a load
// per combined-row cell. Intake pauses from the final sample until the last beat loads.
// Reset clears per-cell valid bits at once, so the table reads zero; no clearing pass.
// ----------------------------------------------------------------------------
// genotype_phenotype_count_table
// genotype by phenotype contingency counts with row/column readout per marker
// ----------------------------------------------------------------------------
`include "genotype_phenotype_count_table_defines.svh"

module genotype_phenotype_count_table (
    input  logic        clk,
    input  logic        rst_n,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // genotype_code[1:0], phenotype_class[5:2], zero pad
    input  logic        s_axis_tlast,   // final_sample
    // table stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // table_row[3:0], table_column[5:4],
                                        // cell_count[25:6], zero pad
    output logic        m_axis_tlast,   // end_of_table
    // class count register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data        // phenotype_classes
);

    import gpct_pkg::*;

    logic       cls_over;
    row_t       classes_reg;
    row_t       classes_eff;
    logic       in_accept;
    rdo_ctl_t   rdo_ctl;
    smp_stat_t  stat;
    logic       ram_re;
    addr_t      ram_raddr;
    logic       ram_we;
    addr_t      ram_waddr;
    count_t     ram_wdata;
    count_t     ram_rdata;
    row_t       out_row;
    col_t       out_col;
    out_count_t out_count;

    // class count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            classes_reg <= ROW_BITS'(2);
        else if (cfg_valid)
            classes_reg <= cfg_data;
    end

    assign cls_over    = (classes_reg > ROW_BITS'(MAX_CLASSES));
    assign classes_eff = cls_over ? ROW_BITS'(MAX_CLASSES) : classes_reg;

    // intake stops from the final sample until the readout ends
    assign s_axis_tready = !rdo_ctl.busy && !stat.final_done;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    gpct_cell_ram #(
        .DATA_W (COUNT_BITS),
        .ADDR_W (ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gpct_sample_path u_sample (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .in_geno   (s_axis_tdata[1:0]),
        .in_pheno  (s_axis_tdata[5:2]),
        .in_final  (s_axis_tlast),
        .classes   (classes_eff),
        .rdo_ctl   (rdo_ctl),
        .ram_rdata (ram_rdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .stat      (stat)
    );

    gpct_readout u_readout (
        .clk       (clk),
        .rst_n     (rst_n),
        .classes   (classes_eff),
        .stat      (stat),
        .ram_rdata (ram_rdata),
        .ctl       (rdo_ctl),
        .out_vld   (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, out_count, out_col, out_row};

    // checks
    `GPCT_ASSERT_NOW(a_no_intake_in_readout, rdo_ctl.busy, !s_axis_tready,
        "sample accepted while the table is read out")
    `GPCT_ASSERT_NEXT(a_final_stops_intake, in_accept && s_axis_tlast, !s_axis_tready,
        "intake continued after the final sample")
    `GPCT_ASSERT_NOW(a_readout_port_free, rdo_ctl.rd_en, !in_accept && !ram_we,
        "readout read collides with a sample access")
    `GPCT_ASSERT_NOW(a_last_beat_last_col, m_axis_tvalid && m_axis_tlast,
        (out_col == LAST_COL) && (out_row == classes_eff),
        "end of table not on the last combined cell")

endmodule

// ===== src/gpct_cell_ram.sv =====
// ----------------------------------------------------------------------------
// gpct_cell_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module gpct_cell_ram #(
    parameter int DATA_W = 20,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [1 << ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gpct_sample_path.sv =====
// ----------------------------------------------------------------------------
// gpct_sample_path
// read-modify-write of one counter per sample with write forwarding
// ----------------------------------------------------------------------------
module gpct_sample_path (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_accept,
    input  gpct_pkg::col_t     in_geno,
    input  gpct_pkg::row_t     in_pheno,
    input  logic               in_final,
    input  gpct_pkg::row_t     classes,
    input  gpct_pkg::rdo_ctl_t rdo_ctl,
    input  gpct_pkg::count_t   ram_rdata,
    output logic               ram_re,
    output gpct_pkg::addr_t    ram_raddr,
    output logic               ram_we,
    output gpct_pkg::addr_t    ram_waddr,
    output gpct_pkg::count_t   ram_wdata,
    output gpct_pkg::smp_stat_t stat
);

    import gpct_pkg::*;

    logic                  s_vld_reg, s_vld_next;
    logic                  s_en_reg;
    logic                  s_final_reg;
    addr_t                 s_addr_reg;
    logic                  wr_vld_reg, wr_vld_next;
    addr_t                 wr_addr_reg;
    count_t                wr_data_reg;
    logic [CELL_DEPTH-1:0] valid_reg;
    logic                  count_en;
    count_t                cur_count;
    count_t                new_count;

    // sample is counted only inside the table
    assign count_en = (in_pheno < classes) &&
                      ({1'b0, in_geno} < (COL_BITS + 1)'(GENOTYPE_COLUMNS));

    // memory read port shared with readout
    assign ram_re    = in_accept || rdo_ctl.rd_en;
    assign ram_raddr = rdo_ctl.busy ? rdo_ctl.rd_addr : cell_addr(in_pheno, in_geno);

    // current value: forwarded, stored or cleared
    always_comb
    begin
        if (wr_vld_reg && (wr_addr_reg == s_addr_reg))
            cur_count = wr_data_reg;
        else if (valid_reg[s_addr_reg])
            cur_count = ram_rdata;
        else
            cur_count = '0;
        new_count = (cur_count == CELL_FULL) ? cur_count : cur_count + 1'b1;
    end

    assign ram_we    = s_vld_reg && s_en_reg;
    assign ram_waddr = s_addr_reg;
    assign ram_wdata = new_count;

    assign s_vld_next  = in_accept;
    assign wr_vld_next = ram_we;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_vld_reg  <= 1'b0;
            wr_vld_reg <= 1'b0;
        end
        else
        begin
            s_vld_reg  <= s_vld_next;
            wr_vld_reg <= wr_vld_next;
        end
    end

    // per-cell valid bits, all cleared after a readout
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (rdo_ctl.clear)
            valid_reg <= '0;
        else if (ram_we)
            valid_reg[s_addr_reg] <= 1'b1;
    end

    // stage and forwarding payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_en_reg    <= count_en;
            s_final_reg <= in_final;
            s_addr_reg  <= cell_addr(in_pheno, in_geno);
        end
        wr_addr_reg <= s_addr_reg;
        wr_data_reg <= new_count;
    end

    assign stat.final_done = s_vld_reg && s_final_reg;
    assign stat.cell_valid = valid_reg[rdo_ctl.rd_addr];

endmodule

// ===== src/gpct_readout.sv =====
// ----------------------------------------------------------------------------
// gpct_readout
// walks the table after the final sample, builds column sums, output register
// ----------------------------------------------------------------------------
module gpct_readout (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gpct_pkg::row_t        classes,
    input  gpct_pkg::smp_stat_t   stat,
    input  gpct_pkg::count_t      ram_rdata,
    output gpct_pkg::rdo_ctl_t    ctl,
    output logic                  out_vld,
    input  logic                  out_ready,
    output gpct_pkg::row_t        out_row,
    output gpct_pkg::col_t        out_col,
    output gpct_pkg::out_count_t  out_count,
    output logic                  out_last
);

    import gpct_pkg::*;

    rd_state_t  state_reg, state_next;
    row_t       row_reg, row_next;
    col_t       col_reg, col_next;
    count_t     colsum_reg [GENOTYPE_COLUMNS];
    logic       out_vld_reg, out_vld_next;
    row_t       out_row_reg;
    col_t       out_col_reg;
    out_count_t out_count_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       load;
    logic       load_sum;
    logic       sum_clear;
    count_t     cell_val;

    assign out_free = !out_vld_reg || out_ready;
    assign cell_val = stat.cell_valid ? ram_rdata : '0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        unique case (state_reg)
            RD_IDLE:
            begin
                if (stat.final_done)
                begin
                    row_next   = '0;
                    col_next   = '0;
                    state_next = (classes == '0) ? RD_SUM : RD_ISSUE;
                end
            end
            RD_ISSUE:
                state_next = RD_WAIT;
            RD_WAIT:
            begin
                if (out_free)
                begin
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (ROW_BITS'(row_reg + 1'b1) == classes)
                            state_next = RD_SUM;
                        else
                        begin
                            row_next   = row_reg + 1'b1;
                            state_next = RD_ISSUE;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = RD_ISSUE;
                    end
                end
            end
            RD_SUM:
            begin
                if (out_free)
                begin
                    if (col_reg == LAST_COL)
                        state_next = RD_IDLE;
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            default:
                state_next = RD_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctl.busy    = 1'b1;
        ctl.clear   = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.rd_addr = cell_addr(row_reg, col_reg);
        load        = 1'b0;
        load_sum    = 1'b0;
        sum_clear   = 1'b0;
        unique case (state_reg)
            RD_IDLE:
            begin
                ctl.busy  = 1'b0;
                sum_clear = stat.final_done;
            end
            RD_ISSUE:
                ctl.rd_en = 1'b1;
            RD_WAIT:
                load = out_free;
            RD_SUM:
            begin
                load_sum  = out_free;
                ctl.clear = out_free && (col_reg == LAST_COL);
            end
            default:
                ctl.busy = 1'b0;
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (load || load_sum)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= RD_IDLE;
            row_reg     <= '0;
            col_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // column sums over the true rows
    always_ff @(posedge clk)
    begin
        if (sum_clear)
        begin
            for (int i = 0; i < GENOTYPE_COLUMNS; i++)
                colsum_reg[i] <= '0;
        end
        else if (load)
            colsum_reg[col_reg] <= sat_add(colsum_reg[col_reg], cell_val);
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_count_reg <= fit_out(cell_val);
            out_last_reg  <= 1'b0;
        end
        else if (load_sum)
        begin
            out_row_reg   <= classes;
            out_col_reg   <= col_reg;
            out_count_reg <= fit_out(colsum_reg[col_reg]);
            out_last_reg  <= (col_reg == LAST_COL);
        end
    end

    assign out_vld   = out_vld_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

endmodule
